// ===== rtl/core/pdv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdv_pkg
// Widths, angle constants, sequencer states and the arctangent table shared
// by the pose difference velocity block.
// ----------------------------------------------------------------------------
package pdv_pkg;

   localparam int PosW   = 32;
   localparam int QuatW  = 16;
   localparam int TimeW  = 63;
   localparam int SpeedW = 31;
   localparam int RateW  = 32;
   localparam int YawW   = 16;

   // CORDIC datapath
   localparam int CordicW     = 45;
   localparam int AngleW      = 24;
   localparam int CordicSteps = 20;

   localparam logic signed [YawW-1:0]   PI_Q13     = 16'sd25736;
   localparam logic signed [YawW:0]     TWO_PI_Q13 = 17'sd51472;
   localparam logic signed [AngleW-1:0] PI_Q20     = 24'sd3294199;

   localparam logic [59:0] NS2_PER_S2 = 60'd1000000000000000000;
   localparam logic [29:0] NS_PER_S   = 30'd1000000000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PROD,
      ST_PREP,
      ST_NORM,
      ST_ROT,
      ST_YAW,
      ST_SQUARE,
      ST_SCALE,
      ST_ROOT,
      ST_DIV_SPEED,
      ST_DIV_TURN,
      ST_OUT
   } state_type;

   // atan(2^-i) in units of 2^-20 rad
   function automatic logic [19:0] atan_entry(input logic [4:0] idx);
      logic [19:0] v;
      case (idx)
         5'd0:    v = 20'd823550;
         5'd1:    v = 20'd486170;
         5'd2:    v = 20'd256879;
         5'd3:    v = 20'd130396;
         5'd4:    v = 20'd65451;
         5'd5:    v = 20'd32757;
         5'd6:    v = 20'd16383;
         5'd7:    v = 20'd8192;
         5'd8:    v = 20'd4096;
         5'd9:    v = 20'd2048;
         5'd10:   v = 20'd1024;
         5'd11:   v = 20'd512;
         5'd12:   v = 20'd256;
         5'd13:   v = 20'd128;
         5'd14:   v = 20'd64;
         5'd15:   v = 20'd32;
         5'd16:   v = 20'd16;
         5'd17:   v = 20'd8;
         5'd18:   v = 20'd4;
         5'd19:   v = 20'd2;
         default: v = 20'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pose_difference_velocity.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pose_difference_velocity
// Planar linear speed and turn rate from consecutive timestamped poses.
// ----------------------------------------------------------------------------
// One pose transaction is worked at a time. Yaw comes from the quaternion
// through a shared 16x16 multiplier, a one-bit-per-cycle normalizing shift
// and 20 CORDIC vectoring steps; a zero quaternion skips normalize and
// CORDIC. The first pose and any pose whose time does not advance finish
// there and give no result. A pose that does advance then goes through a
// bit-serial multiply of the squared distance by 10^18, a two-bit-per-cycle
// square root and one restoring divider used twice, for speed and for turn
// rate. The result then waits until the output register is empty or being
// drained. req_stall stays high while a pose is in work; a finished result
// sits in the output register and the next pose is accepted while it waits
// to be taken. Speed and turn rate saturate in Q16.16; the pose and its
// time are echoed unchanged.
// ----------------------------------------------------------------------------
module pose_difference_velocity (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // pose input
   input  wire logic                              req_valid,
   output      logic                              req_stall,
   input  wire logic signed [pdv_pkg::PosW-1:0]   req_pos_x,
   input  wire logic signed [pdv_pkg::PosW-1:0]   req_pos_y,
   input  wire logic signed [pdv_pkg::QuatW-1:0]  req_quat_x,
   input  wire logic signed [pdv_pkg::QuatW-1:0]  req_quat_y,
   input  wire logic signed [pdv_pkg::QuatW-1:0]  req_quat_z,
   input  wire logic signed [pdv_pkg::QuatW-1:0]  req_quat_w,
   input  wire logic        [pdv_pkg::TimeW-1:0]  req_arrival_time,
   // velocity result
   output      logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   output      logic        [pdv_pkg::SpeedW-1:0] rsp_linear_speed,
   output      logic signed [pdv_pkg::RateW-1:0]  rsp_turn_rate,
   output      logic        [pdv_pkg::TimeW-1:0]  rsp_stamp,
   output      logic signed [pdv_pkg::PosW-1:0]   rsp_echo_x,
   output      logic signed [pdv_pkg::PosW-1:0]   rsp_echo_y,
   output      logic signed [pdv_pkg::QuatW-1:0]  rsp_echo_qx,
   output      logic signed [pdv_pkg::QuatW-1:0]  rsp_echo_qy,
   output      logic signed [pdv_pkg::QuatW-1:0]  rsp_echo_qz,
   output      logic signed [pdv_pkg::QuatW-1:0]  rsp_echo_qw
);
   import pdv_pkg::*;

   // sequencer
   state_type state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;

   // captured pose
   logic signed [PosW-1:0]  in_x_ff, in_x_in, in_y_ff, in_y_in;
   logic signed [QuatW-1:0] qx_ff, qx_in, qy_ff, qy_in, qz_ff, qz_in, qw_ff, qw_in;
   logic [TimeW-1:0]        t_ff, t_in;

   // atan2 arguments before doubling of ay
   logic signed [33:0] acc_ax_ff, acc_ax_in, acc_ay_ff, acc_ay_in;

   // CORDIC
   logic signed [CordicW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [AngleW-1:0]  z_ff, z_in;
   logic signed [YawW-1:0]    yaw_ff, yaw_in;

   // rate work
   logic [TimeW-1:0] dt_ff, dt_in;
   logic             turn_neg_ff, turn_neg_in;
   logic [14:0]      turn_abs_ff, turn_abs_in;
   logic [64:0]      sq_ff, sq_in;
   logic [124:0]     prod_ff, prod_in;
   logic [125:0]     rad_ff, rad_in;
   logic [64:0]      rem_ff, rem_in;
   logic [62:0]      root_ff, root_in;
   logic [63:0]      div_n_ff, div_n_in, div_r_ff, div_r_in;
   logic [SpeedW-1:0] speed_ff, speed_in;
   logic signed [RateW-1:0] rate_ff, rate_in;

   // stored pose
   logic                    primed_ff, primed_in;
   logic signed [PosW-1:0]  prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [YawW-1:0]  prev_yaw_ff, prev_yaw_in;
   logic [TimeW-1:0]        prev_time_ff, prev_time_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SpeedW-1:0]       rsp_speed_ff, rsp_speed_in;
   logic signed [RateW-1:0] rsp_rate_ff, rsp_rate_in;
   logic [TimeW-1:0]        rsp_stamp_ff, rsp_stamp_in;
   logic signed [PosW-1:0]  rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic signed [QuatW-1:0] rsp_qx_ff, rsp_qx_in, rsp_qy_ff, rsp_qy_in;
   logic signed [QuatW-1:0] rsp_qz_ff, rsp_qz_in, rsp_qw_ff, rsp_qw_in;

   // datapath wires
   logic signed [QuatW-1:0]   mul_a, mul_b;
   logic signed [31:0]        mul_p;
   logic signed [33:0]        mul_ext;
   logic signed [CordicW-1:0] ax_full, ay_full, tx, ty;
   logic signed [AngleW-1:0]  atan_ext, z_rnd;
   logic signed [YawW:0]      yaw_r, dyaw, dyaw_w;
   logic signed [YawW-1:0]    yaw_new;
   logic signed [YawW:0]      pi_wide;
   logic                      cx_small, cy_small;
   logic signed [PosW:0]      dx, dy;
   logic [31:0]               dx_abs, dy_abs;
   logic [63:0]               dx_sq, dy_sq;
   logic [124:0]              prod_next;
   logic [66:0]               rem_sh, trial;
   logic                      root_bit;
   logic [62:0]               root_next;
   logic [63:0]               div_sh, quot;
   logic                      div_bit;
   logic [44:0]               turn_mag;
   logic                      load_out;

   // shared multiplier for the quaternion products
   always_comb begin
      case (cnt_ff[2:0])
         3'd0:    begin mul_a = qw_ff; mul_b = qz_ff; end
         3'd1:    begin mul_a = qx_ff; mul_b = qy_ff; end
         3'd2:    begin mul_a = qw_ff; mul_b = qw_ff; end
         3'd3:    begin mul_a = qx_ff; mul_b = qx_ff; end
         3'd4:    begin mul_a = qy_ff; mul_b = qy_ff; end
         default: begin mul_a = qz_ff; mul_b = qz_ff; end
      endcase
   end
   assign mul_p   = mul_a * mul_b;
   assign mul_ext = {{2{mul_p[31]}}, mul_p};

   assign ax_full = {{11{acc_ax_ff[33]}}, acc_ax_ff};
   assign ay_full = {{10{acc_ay_ff[33]}}, acc_ay_ff, 1'b0};

   // normalize until the larger magnitude reaches 2^40
   assign cx_small = (cx_ff[44:40] == 5'b00000);
   assign cy_small = (cy_ff[44:40] == 5'b00000) ||
                     ((cy_ff[44:40] == 5'b11111) && (cy_ff[39:0] != 40'd0));

   assign tx       = cx_ff >>> cnt_ff[4:0];
   assign ty       = cy_ff >>> cnt_ff[4:0];
   assign atan_ext = signed'({4'b0000, atan_entry(cnt_ff[4:0])});

   // pi sign-extended so the compares below stay signed
   assign pi_wide = signed'({PI_Q13[15], PI_Q13});

   // round to Q3.13 and clamp to +-pi
   assign z_rnd = z_ff + 24'sd64;
   assign yaw_r = z_rnd[23:7];
   always_comb begin
      if (yaw_r > pi_wide)
         yaw_new = PI_Q13;
      else if (yaw_r < -pi_wide)
         yaw_new = -PI_Q13;
      else
         yaw_new = yaw_r[15:0];
   end

   // yaw change wrapped once
   assign dyaw = {yaw_new[15], yaw_new} - {prev_yaw_ff[15], prev_yaw_ff};
   always_comb begin
      if (dyaw > pi_wide)
         dyaw_w = dyaw - TWO_PI_Q13;
      else if (dyaw < -pi_wide)
         dyaw_w = dyaw + TWO_PI_Q13;
      else
         dyaw_w = dyaw;
   end

   // squared distance
   assign dx     = {in_x_ff[31], in_x_ff} - {prev_x_ff[31], prev_x_ff};
   assign dy     = {in_y_ff[31], in_y_ff} - {prev_y_ff[31], prev_y_ff};
   assign dx_abs = dx[32] ? 32'(-dx) : dx[31:0];
   assign dy_abs = dy[32] ? 32'(-dy) : dy[31:0];
   assign dx_sq  = dx_abs * dx_abs;
   assign dy_sq  = dy_abs * dy_abs;

   // serial multiply by 10^18, MSB of the constant first
   assign prod_next = {prod_ff[123:0], 1'b0} +
                      (NS2_PER_S2[6'd59 - cnt_ff] ? {60'd0, sq_ff} : 125'd0);

   // square root, two radicand bits per step
   assign rem_sh    = {rem_ff, rad_ff[125:124]};
   assign trial     = {2'b00, root_ff, 2'b01};
   assign root_bit  = (rem_sh >= trial);
   assign root_next = {root_ff[61:0], root_bit};

   // restoring divider, one quotient bit per step
   assign div_sh  = {div_r_ff[62:0], div_n_ff[63]};
   assign div_bit = (div_sh >= {1'b0, dt_ff});
   assign quot    = {div_n_ff[62:0], div_bit};

   assign turn_mag = turn_abs_ff * NS_PER_S;

   assign load_out = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      in_x_in      = in_x_ff;
      in_y_in      = in_y_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      qz_in        = qz_ff;
      qw_in        = qw_ff;
      t_in         = t_ff;
      acc_ax_in    = acc_ax_ff;
      acc_ay_in    = acc_ay_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      z_in         = z_ff;
      yaw_in       = yaw_ff;
      dt_in        = dt_ff;
      turn_neg_in  = turn_neg_ff;
      turn_abs_in  = turn_abs_ff;
      sq_in        = sq_ff;
      prod_in      = prod_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      div_n_in     = div_n_ff;
      div_r_in     = div_r_ff;
      speed_in     = speed_ff;
      rate_in      = rate_ff;
      primed_in    = primed_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      prev_yaw_in  = prev_yaw_ff;
      prev_time_in = prev_time_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               in_x_in   = req_pos_x;
               in_y_in   = req_pos_y;
               qx_in     = req_quat_x;
               qy_in     = req_quat_y;
               qz_in     = req_quat_z;
               qw_in     = req_quat_w;
               t_in      = req_arrival_time;
               acc_ax_in = '0;
               acc_ay_in = '0;
               cnt_in    = '0;
               state_in  = ST_PROD;
            end
         end
         ST_PROD: begin
            if (cnt_ff < 6'd2)
               acc_ay_in = acc_ay_ff + mul_ext;
            else if (cnt_ff < 6'd4)
               acc_ax_in = acc_ax_ff + mul_ext;
            else
               acc_ax_in = acc_ax_ff - mul_ext;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd5)
               state_in = ST_PREP;
         end
         ST_PREP: begin
            if (acc_ax_ff == '0 && acc_ay_ff == '0) begin
               z_in     = '0;
               state_in = ST_YAW;
            end else begin
               if (acc_ax_ff < 0) begin
                  z_in  = (acc_ay_ff < 0) ? -PI_Q20 : PI_Q20;
                  cx_in = -ax_full;
                  cy_in = -ay_full;
               end else begin
                  z_in  = '0;
                  cx_in = ax_full;
                  cy_in = ay_full;
               end
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (cx_small && cy_small) begin
               cx_in = cx_ff <<< 1;
               cy_in = cy_ff <<< 1;
            end else begin
               cnt_in   = '0;
               state_in = ST_ROT;
            end
         end
         ST_ROT: begin
            if (cy_ff > 0) begin
               cx_in = cx_ff + ty;
               cy_in = cy_ff - tx;
               z_in  = z_ff + atan_ext;
            end else begin
               cx_in = cx_ff - ty;
               cy_in = cy_ff + tx;
               z_in  = z_ff - atan_ext;
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(CordicSteps - 1))
               state_in = ST_YAW;
         end
         ST_YAW: begin
            if (!primed_ff) begin
               // first pose only primes the stored state
               primed_in    = 1'b1;
               prev_x_in    = in_x_ff;
               prev_y_in    = in_y_ff;
               prev_yaw_in  = yaw_new;
               prev_time_in = t_ff;
               state_in     = ST_IDLE;
            end else if (t_ff <= prev_time_ff) begin
               state_in = ST_IDLE;
            end else begin
               yaw_in      = yaw_new;
               dt_in       = t_ff - prev_time_ff;
               turn_neg_in = dyaw_w[16];
               turn_abs_in = dyaw_w[16] ? 15'(-dyaw_w) : dyaw_w[14:0];
               state_in    = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            sq_in    = {1'b0, dx_sq} + {1'b0, dy_sq};
            prod_in  = '0;
            cnt_in   = '0;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            prod_in = prod_next;
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff == 6'd59) begin
               rad_in   = {1'b0, prod_next};
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = '0;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            rem_in  = root_bit ? 65'(rem_sh - trial) : rem_sh[64:0];
            root_in = root_next;
            rad_in  = {rad_ff[123:0], 2'b00};
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff == 6'd62) begin
               div_n_in = {1'b0, root_next};
               div_r_in = '0;
               cnt_in   = '0;
               state_in = ST_DIV_SPEED;
            end
         end
         ST_DIV_SPEED: begin
            div_r_in = div_bit ? (div_sh - {1'b0, dt_ff}) : div_sh;
            div_n_in = quot;
            cnt_in   = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               speed_in = (quot[63:31] != '0) ? {SpeedW{1'b1}} : quot[30:0];
               div_n_in = {16'd0, turn_mag, 3'b000};
               div_r_in = '0;
               cnt_in   = '0;
               state_in = ST_DIV_TURN;
            end
         end
         ST_DIV_TURN: begin
            div_r_in = div_bit ? (div_sh - {1'b0, dt_ff}) : div_sh;
            div_n_in = quot;
            cnt_in   = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               if (turn_neg_ff) begin
                  if (quot[63:32] != '0 || (quot[31] && quot[30:0] != '0))
                     rate_in = {1'b1, {(RateW-1){1'b0}}};
                  else
                     rate_in = signed'(~quot[31:0] + 32'd1);
               end else begin
                  if (quot[63:31] != '0)
                     rate_in = {1'b0, {(RateW-1){1'b1}}};
                  else
                     rate_in = signed'(quot[31:0]);
               end
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (load_out) begin
               prev_x_in    = in_x_ff;
               prev_y_in    = in_y_ff;
               prev_yaw_in  = yaw_ff;
               prev_time_in = t_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output register: loads when empty or being drained
   always_comb begin
      rsp_valid_in = load_out ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_speed_in = load_out ? speed_ff : rsp_speed_ff;
      rsp_rate_in  = load_out ? rate_ff  : rsp_rate_ff;
      rsp_stamp_in = load_out ? t_ff     : rsp_stamp_ff;
      rsp_x_in     = load_out ? in_x_ff  : rsp_x_ff;
      rsp_y_in     = load_out ? in_y_ff  : rsp_y_ff;
      rsp_qx_in    = load_out ? qx_ff    : rsp_qx_ff;
      rsp_qy_in    = load_out ? qy_ff    : rsp_qy_ff;
      rsp_qz_in    = load_out ? qz_ff    : rsp_qz_ff;
      rsp_qw_in    = load_out ? qw_ff    : rsp_qw_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         primed_ff    <= 1'b0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         prev_yaw_ff  <= '0;
         prev_time_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         primed_ff    <= primed_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         prev_yaw_ff  <= prev_yaw_in;
         prev_time_ff <= prev_time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_x_ff      <= in_x_in;
      in_y_ff      <= in_y_in;
      qx_ff        <= qx_in;
      qy_ff        <= qy_in;
      qz_ff        <= qz_in;
      qw_ff        <= qw_in;
      t_ff         <= t_in;
      acc_ax_ff    <= acc_ax_in;
      acc_ay_ff    <= acc_ay_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      z_ff         <= z_in;
      yaw_ff       <= yaw_in;
      dt_ff        <= dt_in;
      turn_neg_ff  <= turn_neg_in;
      turn_abs_ff  <= turn_abs_in;
      sq_ff        <= sq_in;
      prod_ff      <= prod_in;
      rad_ff       <= rad_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      div_n_ff     <= div_n_in;
      div_r_ff     <= div_r_in;
      speed_ff     <= speed_in;
      rate_ff      <= rate_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_rate_ff  <= rsp_rate_in;
      rsp_stamp_ff <= rsp_stamp_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_qx_ff    <= rsp_qx_in;
      rsp_qy_ff    <= rsp_qy_in;
      rsp_qz_ff    <= rsp_qz_in;
      rsp_qw_ff    <= rsp_qw_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_linear_speed = rsp_speed_ff;
   assign rsp_turn_rate    = rsp_rate_ff;
   assign rsp_stamp        = rsp_stamp_ff;
   assign rsp_echo_x       = rsp_x_ff;
   assign rsp_echo_y       = rsp_y_ff;
   assign rsp_echo_qx      = rsp_qx_ff;
   assign rsp_echo_qy      = rsp_qy_ff;
   assign rsp_echo_qz      = rsp_qz_ff;
   assign rsp_echo_qw      = rsp_qw_ff;

endmodule
`default_nettype wire

// ===== rtl/core/pdv_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdv_checker
// Port-level checks for the pose difference velocity block.
// ----------------------------------------------------------------------------
module pdv_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_stall,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic        [pdv_pkg::SpeedW-1:0] rsp_linear_speed,
   input wire logic signed [pdv_pkg::RateW-1:0]  rsp_turn_rate,
   input wire logic        [pdv_pkg::TimeW-1:0]  rsp_stamp,
   input wire logic signed [pdv_pkg::PosW-1:0]   rsp_echo_x,
   input wire logic signed [pdv_pkg::PosW-1:0]   rsp_echo_y,
   input wire logic signed [pdv_pkg::QuatW-1:0]  rsp_echo_qx,
   input wire logic signed [pdv_pkg::QuatW-1:0]  rsp_echo_qy,
   input wire logic signed [pdv_pkg::QuatW-1:0]  rsp_echo_qz,
   input wire logic signed [pdv_pkg::QuatW-1:0]  rsp_echo_qw
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // one pose at a time: busy right after a transaction
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("pose accepted while another is in work");

   // a result never appears the cycle after a pose is taken
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   // stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_stamp)
                                    && $stable(rsp_turn_rate)
                                    && $stable(rsp_linear_speed)
                                    && $stable(rsp_echo_x) && $stable(rsp_echo_y)
                                    && $stable(rsp_echo_qx) && $stable(rsp_echo_qy)
                                    && $stable(rsp_echo_qz) && $stable(rsp_echo_qw)))
      else $error("stalled result changed");

endmodule

bind pose_difference_velocity pdv_checker u_pdv_checker (.*);
`default_nettype wire

// ===== tb/pose_difference_velocity_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_difference_velocity_test
// Self-checking bench for the pose difference velocity block: directed corner
// poses, then randomized pose tracks, with random sender gaps and receiver
// stalls. Every result transaction is checked field by field against a
// bit-exact predictor held in a small scoreboard class.
// ----------------------------------------------------------------------------
module pose_difference_velocity_test;
   import pdv_pkg::*;

   typedef struct {
      logic signed [PosW-1:0]  x, y;
      logic signed [QuatW-1:0] qx, qy, qz, qw;
      logic        [TimeW-1:0] t;
   } pose_type;

   typedef struct {
      logic        [SpeedW-1:0] speed;
      logic signed [RateW-1:0]  rate;
      logic        [TimeW-1:0]  stamp;
      logic signed [PosW-1:0]   ex, ey;
      logic signed [QuatW-1:0]  eqx, eqy, eqz, eqw;
   } velocity_type;

   // Predictor plus queue of expected velocity transactions.
   class velocity_scoreboard;
      velocity_type expected_q[$];
      int        failures;
      bit        primed;
      logic signed [PosW-1:0]  last_x, last_y;
      int                      last_yaw;   // Q3.13 radians
      logic        [TimeW-1:0] last_t;
      longint                  atan_lut[CordicSteps] = '{
         823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192, 4096, 2048,
         1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

      // yaw = atan2(2(wz+xy), w^2+x^2-y^2-z^2) via 20 vectoring steps
      function int heading(pose_type p);
         longint ax, ay, ang, m, tx, ty, r;
         ay  = 2 * (longint'(p.qw) * p.qz + longint'(p.qx) * p.qy);
         ax  = longint'(p.qw) * p.qw + longint'(p.qx) * p.qx
               - longint'(p.qy) * p.qy - longint'(p.qz) * p.qz;
         ang = 0;
         if (ax == 0 && ay == 0) return 0;
         if (ax < 0) begin
            ang = (ay < 0) ? -longint'(PI_Q20) : longint'(PI_Q20);
            ax  = -ax;
            ay  = -ay;
         end
         m = (ay < 0) ? -ay : ay;
         if (ax > m) m = ax;
         while (m < (64'sd1 <<< 40)) begin
            ax = ax * 2;
            ay = ay * 2;
            m  = m * 2;
         end
         for (int i = 0; i < CordicSteps; i++) begin
            tx = ax >>> i;
            ty = ay >>> i;
            if (ay > 0) begin
               ax += ty; ay -= tx; ang += atan_lut[i];
            end else begin
               ax -= ty; ay += tx; ang -= atan_lut[i];
            end
         end
         r = (ang + 64) >>> 7;
         if (r > PI_Q13) r = PI_Q13;
         if (r < -longint'(PI_Q13)) r = -longint'(PI_Q13);
         return int'(r);
      endfunction

      function void note_pose(pose_type p);
         int           yaw, dyaw;
         longint       dx, dy, adx, ady;
         logic [127:0] energy, root, cand;
         logic [63:0]  dt, turn_mag, q;
         velocity_type v;
         yaw = heading(p);
         if (primed && p.t <= last_t) return;   // stale pose: dropped
         if (primed) begin
            dt  = 64'(p.t - last_t);
            dx  = longint'(p.x) - longint'(last_x);
            dy  = longint'(p.y) - longint'(last_y);
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            energy = (128'(adx) * 128'(adx) + 128'(ady) * 128'(ady)) * 128'(NS2_PER_S2);
            root = '0;
            for (int b = 63; b >= 0; b--) begin
               cand = root | (128'd1 << b);
               if (cand * cand <= energy) root = cand;
            end
            root = root / 128'(dt);
            v.speed = (root > 128'h7FFF_FFFF) ? '1 : root[SpeedW-1:0];
            dyaw = yaw - last_yaw;
            if (dyaw > PI_Q13) dyaw -= TWO_PI_Q13;
            else if (dyaw < -int'(PI_Q13)) dyaw += TWO_PI_Q13;
            turn_mag = 64'((dyaw < 0) ? -dyaw : dyaw) * 64'd8 * 64'(NS_PER_S);
            q = turn_mag / dt;
            if (dyaw < 0)
               v.rate = (q > 64'h8000_0000) ? 32'sh8000_0000 : -q[31:0];
            else
               v.rate = (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
            v.stamp = p.t;
            v.ex  = p.x;  v.ey  = p.y;
            v.eqx = p.qx; v.eqy = p.qy; v.eqz = p.qz; v.eqw = p.qw;
            expected_q.push_back(v);
         end
         primed   = 1'b1;
         last_x   = p.x;
         last_y   = p.y;
         last_yaw = yaw;
         last_t   = p.t;
      endfunction

      function void compare(string name, logic [63:0] exp_v, logic [63:0] act_v);
         if (exp_v !== act_v) begin
            failures++;
            $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v,
                     act_v);
         end
      endfunction

      function void check_result(velocity_type a);
         velocity_type e;
         if (expected_q.size() == 0) begin
            failures++;
            $display("%0t: unexpected velocity transaction, expected none, actual stamp %h",
                     $realtime, a.stamp);
            return;
         end
         e = expected_q.pop_front();
         compare("linear_speed", 64'(e.speed), 64'(a.speed));
         compare("turn_rate", 64'(e.rate), 64'(a.rate));
         compare("stamp", 64'(e.stamp), 64'(a.stamp));
         compare("echo_x", 64'(e.ex), 64'(a.ex));
         compare("echo_y", 64'(e.ey), 64'(a.ey));
         compare("echo_qx", 64'(e.eqx), 64'(a.eqx));
         compare("echo_qy", 64'(e.eqy), 64'(a.eqy));
         compare("echo_qz", 64'(e.eqz), 64'(a.eqz));
         compare("echo_qw", 64'(e.eqw), 64'(a.eqw));
      endfunction
   endclass

   localparam int HangLimit  = 5000;   // well above the longest time one pose takes
   localparam int DrainWait  = 400;
   localparam int RandomPoses = 1550;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [PosW-1:0]    req_pos_x = '0, req_pos_y = '0;
   logic signed [QuatW-1:0]   req_quat_x = '0, req_quat_y = '0;
   logic signed [QuatW-1:0]   req_quat_z = '0, req_quat_w = '0;
   logic        [TimeW-1:0]   req_arrival_time = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic        [SpeedW-1:0]  rsp_linear_speed;
   logic signed [RateW-1:0]   rsp_turn_rate;
   logic        [TimeW-1:0]   rsp_stamp;
   logic signed [PosW-1:0]    rsp_echo_x, rsp_echo_y;
   logic signed [QuatW-1:0]   rsp_echo_qx, rsp_echo_qy, rsp_echo_qz, rsp_echo_qw;

   velocity_scoreboard sb = new();
   int   burst_left = 0;
   int   quiet_cycles = 0;
   logic [15:0] stall_bits = '0;
   int   stall_phase = 0;
   pose_type cur;

   always #6 clock = ~clock;

   pose_difference_velocity u_dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_pos_x, .req_pos_y,
      .req_quat_x, .req_quat_y, .req_quat_z, .req_quat_w, .req_arrival_time,
      .rsp_valid, .rsp_stall, .rsp_linear_speed, .rsp_turn_rate, .rsp_stamp,
      .rsp_echo_x, .rsp_echo_y, .rsp_echo_qx, .rsp_echo_qy, .rsp_echo_qz, .rsp_echo_qw
   );

   // Receiver: a random 16-bit stall pattern, cycled through and reloaded
   // periodically; about a quarter of the reloads never stall at all.
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 512 == 0)
         stall_bits <= ($urandom_range(0, 3) == 0) ? 16'h0 : 16'($urandom);
      rsp_stall <= reset ? 1'b0 : stall_bits[stall_phase % 16];
   end

   // Result monitor: values sampled before this edge's updates land.
   always @(posedge clock) begin
      velocity_type a;
      if (!reset && rsp_valid && !rsp_stall) begin
         a.speed = rsp_linear_speed; a.rate = rsp_turn_rate; a.stamp = rsp_stamp;
         a.ex  = rsp_echo_x;  a.ey  = rsp_echo_y;
         a.eqx = rsp_echo_qx; a.eqy = rsp_echo_qy; a.eqz = rsp_echo_qz; a.eqw = rsp_echo_qw;
         sb.check_result(a);
      end
   end

   // Watchdog: any cycle without a transaction on either side counts.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HangLimit) begin
         $display("pose_difference_velocity_test: FAIL");
         $finish;
      end
   end

   // Present one pose and hold it until the block takes it.
   task automatic send_pose(pose_type p);
      req_valid <= 1'b1;
      req_pos_x <= p.x;   req_pos_y <= p.y;
      req_quat_x <= p.qx; req_quat_y <= p.qy; req_quat_z <= p.qz; req_quat_w <= p.qw;
      req_arrival_time <= p.t;
      do @(posedge clock); while (req_stall);
      sb.note_pose(p);
      // bursts of random length, then a random gap (sometimes none)
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 30);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.expected_q.size() > 0) @(posedge clock);
   endtask

   task automatic directed_pose(int x, int y, int qx, int qy, int qz, int qw,
                                logic [TimeW-1:0] t);
      pose_type p;
      p.x = x; p.y = y;
      p.qx = 16'(qx); p.qy = 16'(qy); p.qz = 16'(qz); p.qw = 16'(qw);
      p.t = t;
      cur = p;
      send_pose(p);
   endtask

   // Next pose of a random track: mostly small moves and clean time steps,
   // some stale times, wild jumps and off-range quaternions.
   function automatic pose_type next_track_pose(pose_type prev);
      pose_type p;
      int    kind;
      p = prev;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         p.x = $urandom; p.y = $urandom;
      end else begin
         p.x = prev.x + $signed(32'($urandom_range(0, 1 << 20)) - (1 << 19));
         p.y = prev.y + $signed(32'($urandom_range(0, 1 << 20)) - (1 << 19));
      end
      if ($urandom_range(0, 19) == 0) begin
         p.qx = 16'($urandom); p.qy = 16'($urandom);
         p.qz = 16'($urandom); p.qw = 16'($urandom);
      end else begin
         p.qx = 16'($urandom_range(0, 32768) - 16384);
         p.qy = 16'($urandom_range(0, 32768) - 16384);
         p.qz = 16'($urandom_range(0, 32768) - 16384);
         p.qw = 16'($urandom_range(0, 32768) - 16384);
      end
      kind = $urandom_range(0, 99);
      if (kind < 5)       p.t = prev.t;                                   // same time
      else if (kind < 10) p.t = prev.t - $urandom_range(1, 1 << 20);      // older time
      else if (kind < 14) p.t = prev.t + $urandom_range(1, 4);            // tiny step
      else if (kind < 20) p.t = 63'(prev.t + {$urandom, $urandom} % (64'd1 << 40));
      else if (kind < 22) p.t = 63'(prev.t + {$urandom, $urandom} % (64'd1 << 52));
      else                p.t = prev.t + $urandom_range(1000000, 100000000);
      return p;
   endfunction

   initial begin
      pose_type p;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corners
      directed_pose(0, 0, 0, 0, 0, 0, 63'd1000);                 // zero quaternion primes
      directed_pose(5, 5, 0, 0, 0, 16384, 63'd1000);             // same time: dropped
      directed_pose(5, 5, 0, 0, 0, 16384, 63'd999);              // older time: dropped
      directed_pose(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 16384, 0, 63'd1001);  // dt=1, yaw pi
      directed_pose(32'sh8000_0000, 32'sh8000_0000, 0, 0, -16384, 0, 63'd1002); // yaw pi again
      directed_pose(0, 0, 0, 0, 11585, 11585, 63'd2002);         // +pi/2, turn from pi
      directed_pose(65536, 0, 0, 0, -11585, 11585, 63'd1000000002);
      directed_pose(65536, 65536, 16384, 16384, 16384, 16384, 63'd1000000003);
      directed_pose(0, 0, -16384, -16384, -16384, -16384, 63'd2000000003);
      directed_pose(-1, -1, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 63'd2000000004);
      directed_pose(1, 1, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 63'd3000000004);
      directed_pose(1, 1, 16384, 0, 0, 0, 63'h3FFF_FFFF_FFFF_FFFF); // pitch flip, huge dt
      directed_pose(-65536, 0, 0, -16384, 0, 0, 63'h4000_0000_0000_0000);
      directed_pose(100, -100, 0, 0, -5, 16384, 63'h4000_0000_0000_0010);
      directed_pose(100, -100, 0, 0, 5, -16384, 63'h4000_0000_0000_0011); // same yaw, zero turn
      wait_drained();   // hold-off: sender waits for every result

      cur.t = 63'h4000_0000_0100_0000;   // fresh base just past the directed times
      for (int n = 0; n < RandomPoses; n++) begin
         if (n == RandomPoses / 2) wait_drained();
         p = next_track_pose(cur);
         if (p.t > cur.t || $urandom_range(0, 3) == 0) cur = p;
         send_pose(p);
      end
      // last pose lands on the largest time
      directed_pose(7, 7, 1, 2, 3, 4, 63'h7FFF_FFFF_FFFF_FFFF);

      wait_drained();
      repeat (DrainWait) @(posedge clock);
      if (sb.failures == 0 && sb.expected_q.size() == 0)
         $display("pose_difference_velocity_test: PASS");
      else
         $display("pose_difference_velocity_test: FAIL");
      $finish;
   end

endmodule
